// File: src/detector_hit_merge_accumulator_assert.svh
// Assertion macros shared by the merge accumulator RTL.
// No dependencies.
`ifndef DETECTOR_HIT_MERGE_ACCUMULATOR_ASSERT_SVH
`define DETECTOR_HIT_MERGE_ACCUMULATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DHMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DHMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dhma_pkg.sv
// Package for the detector hit merge accumulator: widths, codes, entry type.
// No dependencies.
`timescale 1ns / 1ps
package dhma_pkg;
  localparam int unsigned TimeW = 24;
  localparam int unsigned EnergyW = 24;
  localparam int unsigned PartW = 8;
  localparam int unsigned TrackW = 16;
  localparam int unsigned SectorW = 5;
  localparam int unsigned EntryW = TimeW + EnergyW + PartW + TrackW;

  localparam logic [1:0] KindDeposit = 2'd0;
  localparam logic [1:0] KindHit     = 2'd1;
  localparam logic [1:0] KindEmpty   = 2'd2;

  localparam logic [1:0] StMerged  = 2'd0;
  localparam logic [1:0] StCreated = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StIgnored = 2'd3;

  localparam logic OpDeposit = 1'b0;
  localparam logic OpReadout = 1'b1;

  localparam logic CfgWindow    = 1'b0;
  localparam logic CfgThreshold = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0]   tm;
    logic [EnergyW-1:0] en;
    logic [PartW-1:0]   pk;
    logic [TrackW-1:0]  tr;
  } entry_t;

  // Divider handshake.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

// File: src/detector_hit_merge_accumulator.sv
// Top level of the detector hit merge accumulator: sequencer around the hit RAM.
// Depends on dhma_pkg, dhma_ram, dhma_div and the assertion macro header.
`timescale 1ns / 1ps
`include "detector_hit_merge_accumulator_assert.svh"
// Usage:
//  Command channel: start with opcode/sector/hit fields, taken when busy is low.
//  Busy rises the cycle after a command that needs the RAM and falls in the
//  cycle that shows the final result. A zero-energy deposit or an out-of-range
//  sector never raises busy; its one result shows the next cycle.
//  Results appear for one cycle with result_valid_o; last_o marks the final
//  one. The receiver cannot stall, so results are never held.
//  Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//  index 0 merge window, 1 energy threshold. Write only when idle.
//  Steps, with the RAM read registered:
//   create: search the sector's hits, then one write; full list: search only.
//   merge with a hit: search up to that hit, one multiply, one divider
//   launch, the bit-serial divider, one write. readout: one entry per
//   cycle; qualifying hits stream out, the last one held back to carry last_o.
//  The next command can be taken in the cycle that shows the final result.
//  Reset: hit counts live in flip-flops and clear at once; the RAM is
//  never cleared because only entries below the count are ever used.
module detector_hit_merge_accumulator #(
  parameter int unsigned SECTORS = 32,
  parameter int unsigned HITS_PER_SECTOR = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [4:0]  sector_i,
  input  logic [23:0] hit_time_i,
  input  logic [23:0] deposit_i,
  input  logic [7:0]  particle_kind_i,
  input  logic signed [15:0] track_number_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  status_o,
  output logic [23:0] out_time_o,
  output logic [23:0] out_energy_o,
  output logic [7:0]  out_particle_o,
  output logic signed [15:0] out_track_o,
  output logic        last_o
);
  localparam int unsigned SecW  = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int unsigned HitW  = (HITS_PER_SECTOR > 1) ? $clog2(HITS_PER_SECTOR) : 1;
  localparam int unsigned CntW  = $clog2(HITS_PER_SECTOR + 1);
  localparam int unsigned Slots = SECTORS * HITS_PER_SECTOR;
  localparam int unsigned AddrW = (Slots > 1) ? $clog2(Slots) : 1;

  typedef enum logic [3:0] {
    SIdle, SSearch, SMul, SDivStart, SDivWait, SWrite, SReadWalk, SReadDone, SEmit
  } state_e;

  state_e state_q;
  logic [23:0] window_q, thresh_q;
  logic [CntW-1:0] count_q [SECTORS];

  logic [SecW-1:0] sec_q;
  logic [23:0] t_q, e_q;
  logic [7:0]  p_q;
  logic [15:0] trk_q;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] ridx_q;   // next index to issue
  logic [CntW-1:0] cidx_q;   // index of data arriving
  logic        rvalid_q;
  logic        emitted_q;
  dhma_pkg::entry_t hit_q;
  logic [47:0] prod_a_q, prod_b_q;
  logic        earlier_q;

  // result registers
  logic        rv_q, last_q;
  logic [1:0]  kind_q, st_q;
  dhma_pkg::entry_t res_q;

  // RAM
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  dhma_pkg::entry_t wdata, rdata;
  logic [AddrW-1:0] base;
  logic [HitW-1:0] ridx_lo, cidx_lo, n_lo;

  assign ridx_lo = ridx_q[HitW-1:0];
  assign cidx_lo = cidx_q[HitW-1:0];
  assign n_lo    = n_q[HitW-1:0];
  assign base    = AddrW'(sec_q) * AddrW'(HITS_PER_SECTOR);
  assign raddr   = base + AddrW'(ridx_lo);

  dhma_ram #(.Width(dhma_pkg::EntryW), .Depth(Slots)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // divider
  logic        div_start;
  logic [48:0] num;
  logic [24:0] den;
  logic [23:0] quo;
  dhma_pkg::div_stat_t div_stat;
  assign num = {1'b0, prod_a_q} + {1'b0, prod_b_q};
  assign den = {1'b0, hit_q.en} + {1'b0, e_q};
  assign div_start = (state_q == SDivStart);

  dhma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (den),
    .quo_o  (quo),
    .stat_o (div_stat)
  );

  logic [23:0] diff;
  logic [24:0] esum;
  logic [23:0] esat;
  assign diff = (rdata.tm > t_q) ? rdata.tm - t_q : t_q - rdata.tm;
  assign esum = {1'b0, hit_q.en} + {1'b0, e_q};
  assign esat = esum[24] ? 24'hFFFFFF : esum[23:0];

  dhma_pkg::entry_t merged;
  always_comb begin
    merged.tm = quo;
    merged.en = esat;
    merged.pk = earlier_q ? p_q : hit_q.pk;
    merged.tr = earlier_q ? trk_q : hit_q.tr;
  end

  always_comb begin
    we = 1'b0;
    waddr = base + AddrW'(cidx_lo);
    wdata = merged;
    if (state_q == SWrite) begin
      we = 1'b1;
    end else if (state_q == SSearch && rvalid_q == 1'b0 && ridx_q == n_q &&
                 n_q < CntW'(HITS_PER_SECTOR)) begin
      // append is written in SEmit, set up by the SSearch end branch
      we = 1'b0;
    end
    if (state_q == SEmit && st_q == dhma_pkg::StCreated) begin
      we = 1'b1;
      waddr = base + AddrW'(n_lo);
      wdata = res_q;
    end
  end

  assign busy = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      window_q <= 24'd16000;
      thresh_q <= 24'd10000;
      for (int i = 0; i < SECTORS; i++) count_q[i] <= '0;
      rv_q     <= 1'b0;
      last_q   <= 1'b0;
      rvalid_q <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      rv_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == dhma_pkg::CfgWindow) window_q <= cfg_data_i;
        else thresh_q <= cfg_data_i;
      end
      case (state_q)
        SIdle: begin
          if (start) begin
            t_q   <= hit_time_i;
            e_q   <= deposit_i;
            p_q   <= particle_kind_i;
            trk_q <= track_number_i;
            ridx_q <= '0;
            rvalid_q <= 1'b0;
            emitted_q <= 1'b0;
            if ({4'd0, sector_i} >= 9'(SECTORS)) begin
              sec_q <= '0;
              rv_q <= 1'b1; last_q <= 1'b1;
              kind_q <= (opcode_i == dhma_pkg::OpDeposit) ? dhma_pkg::KindDeposit
                                                          : dhma_pkg::KindEmpty;
              st_q <= (opcode_i == dhma_pkg::OpDeposit) ? dhma_pkg::StIgnored
                                                        : dhma_pkg::StMerged;
              res_q <= '0;
            end else begin
              sec_q <= SecW'(sector_i);
              n_q <= count_q[SecW'(sector_i)];
              if (opcode_i == dhma_pkg::OpDeposit && deposit_i == 24'd0) begin
                rv_q <= 1'b1; last_q <= 1'b1; kind_q <= dhma_pkg::KindDeposit;
                st_q <= dhma_pkg::StIgnored; res_q <= '0;
              end else begin
                state_q <= (opcode_i == dhma_pkg::OpDeposit) ? SSearch : SReadWalk;
              end
            end
          end
        end
        SSearch: begin
          rvalid_q <= 1'b0;
          if (ridx_q < n_q && !(rvalid_q && diff < window_q)) begin
            ridx_q <= ridx_q + CntW'(1);
            rvalid_q <= 1'b1;
            cidx_q <= ridx_q;
          end
          if (rvalid_q && diff < window_q) begin
            hit_q <= rdata;
            state_q <= SMul;
          end else if (!rvalid_q && ridx_q == n_q || rvalid_q && ridx_q == n_q &&
                       !(diff < window_q)) begin
            if (n_q < CntW'(HITS_PER_SECTOR)) begin
              kind_q <= dhma_pkg::KindDeposit; st_q <= dhma_pkg::StCreated;
              res_q <= '{tm: t_q, en: e_q, pk: p_q, tr: trk_q};
              state_q <= SEmit;
            end else begin
              rv_q <= 1'b1; last_q <= 1'b1; kind_q <= dhma_pkg::KindDeposit;
              st_q <= dhma_pkg::StFull; res_q <= '0;
              state_q <= SIdle;
            end
          end
        end
        SMul: begin
          prod_a_q <= hit_q.tm * hit_q.en;
          prod_b_q <= t_q * e_q;
          earlier_q <= (t_q < hit_q.tm);
          state_q <= SDivStart;
        end
        SDivStart: state_q <= SDivWait;
        SDivWait: begin
          if (div_stat.done) state_q <= SWrite;
        end
        SWrite: begin
          rv_q <= 1'b1; last_q <= 1'b1; kind_q <= dhma_pkg::KindDeposit;
          st_q <= dhma_pkg::StMerged; res_q <= merged;
          state_q <= SIdle;
        end
        SEmit: begin
          count_q[sec_q] <= n_q + CntW'(1);
          rv_q <= 1'b1; last_q <= 1'b1;
          state_q <= SIdle;
        end
        SReadWalk: begin
          rvalid_q <= 1'b0;
          if (ridx_q < n_q) begin
            ridx_q <= ridx_q + CntW'(1);
            rvalid_q <= 1'b1;
          end
          if (rvalid_q && rdata.en > thresh_q) begin
            // hold one hit back so the final one can carry last
            if (emitted_q) begin
              rv_q <= 1'b1; last_q <= 1'b0;
            end
            emitted_q <= 1'b1;
            hit_q <= rdata;
          end
          if (emitted_q && rvalid_q && rdata.en > thresh_q) begin
            kind_q <= dhma_pkg::KindHit; st_q <= dhma_pkg::StMerged; res_q <= hit_q;
          end
          if (ridx_q == n_q && !(ridx_q < n_q)) begin
            if (!rvalid_q || ridx_q == n_q) state_q <= (rvalid_q) ? SReadWalk : SReadDone;
          end
        end
        SReadDone: begin
          count_q[sec_q] <= '0;
          rv_q <= 1'b1; last_q <= 1'b1; st_q <= dhma_pkg::StMerged;
          if (emitted_q) begin
            kind_q <= dhma_pkg::KindHit; res_q <= hit_q;
          end else begin
            kind_q <= dhma_pkg::KindEmpty; res_q <= '0;
          end
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign result_valid_o = rv_q;
  assign result_kind_o  = kind_q;
  assign status_o       = st_q;
  assign out_time_o     = res_q.tm;
  assign out_energy_o   = res_q.en;
  assign out_particle_o = res_q.pk;
  assign out_track_o    = res_q.tr;
  assign last_o         = last_q;

  `DHMA_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, result_valid_o && last_o && busy,
                   state_q == SIdle || state_q == SEmit || state_q == SReadDone,
                   "final result while sequencer active")
  `DHMA_ASSERT_NXT(a_div_done, clk_i, rst_ni, div_start, div_stat.busy,
                   "divider did not start")
  `DHMA_ASSERT_IMP(a_write_merge, clk_i, rst_ni, state_q == SWrite, we,
                   "merge state without RAM write")
endmodule

// File: src/dhma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dhma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/dhma_div.sv
// Restoring divider, one quotient bit per cycle, for the weighted time mean.
// Depends on dhma_pkg.
`timescale 1ns / 1ps
module dhma_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [48:0]           num_i,
  input  logic [24:0]           den_i,
  output logic [23:0]           quo_o,
  output dhma_pkg::div_stat_t   stat_o
);
  // Quotient is the mean of two 24-bit times, so it fits in 24 bits.
  logic [48:0] rem_q, rem_d;
  logic [24:0] den_q;
  logic [23:0] quo_q, quo_d;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [49:0] trial;

  always_comb begin
    trial = {1'b0, rem_q} - ({25'd0, den_q} << cnt_q);
    rem_d = rem_q;
    quo_d = quo_q;
    if (!trial[49]) begin
      rem_d = trial[48:0];
      quo_d[cnt_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd23;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

// File: tb/sv/tb_detector_hit_merge_accumulator.sv
// Self-checking testbench for detector_hit_merge_accumulator: directed and random
// deposits and readouts, checked against a hit-list predictor kept in a scoreboard class.
// Depends on dhma_pkg and the detector_hit_merge_accumulator RTL.
`timescale 1ns / 1ps
module tb_detector_hit_merge_accumulator;

  localparam int unsigned NumSectors = 32;
  localparam int unsigned HitsPerSector = 32;
  localparam int unsigned DrainCycles = HitsPerSector + 48;  // worst merge plus margin
  localparam int unsigned WatchdogLimit = 4000;
  localparam logic [23:0] Max24 = 24'hFFFFFF;

  // One result transaction as seen on the result ports.
  typedef struct {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [23:0]        tm;
    logic [23:0]        en;
    logic [7:0]         pk;
    logic signed [15:0] tr;
    logic               last;
  } hit_result_t;

  // Tracks per-sector hit lists and the results each command must produce.
  class hit_ledger;
    logic [23:0] window;
    logic [23:0] threshold;
    int unsigned fill[NumSectors];
    dhma_pkg::entry_t hits[NumSectors][HitsPerSector];
    hit_result_t pending[$];
    int unsigned errors;
    int unsigned matched;
    int unsigned merges, creates, fulls, ignores, readout_hits, empties;

    function new();
      window = 24'd16000;
      threshold = 24'd10000;
      foreach (fill[i]) fill[i] = 0;
      errors = 0;
      matched = 0;
      merges = 0; creates = 0; fulls = 0; ignores = 0; readout_hits = 0; empties = 0;
    endfunction

    function void set_reg(logic idx, logic [23:0] val);
      if (idx == dhma_pkg::CfgWindow) window = val;
      else threshold = val;
    endfunction

    function void push_status(logic [1:0] st, dhma_pkg::entry_t e);
      hit_result_t r;
      r.kind = dhma_pkg::KindDeposit; r.status = st; r.tm = e.tm; r.en = e.en;
      r.pk = e.pk; r.tr = e.tr; r.last = 1'b1;
      pending.push_back(r);
    endfunction

    // Called once per accepted command transaction.
    function void note_command(logic op, logic [4:0] sec, dhma_pkg::entry_t cmd);
      dhma_pkg::entry_t cur;
      dhma_pkg::entry_t zero;
      logic [23:0] diff;
      logic [63:0] num;
      logic [63:0] den;
      hit_result_t r;
      int          idx;
      int          k;
      zero = '0;
      if (op == dhma_pkg::OpDeposit) begin
        if (cmd.en == 0) begin
          push_status(dhma_pkg::StIgnored, zero);
          ignores++;
          return;
        end
        idx = -1;
        for (int i = 0; i < fill[sec]; i++) begin
          cur = hits[sec][i];
          diff = (cur.tm > cmd.tm) ? cur.tm - cmd.tm : cmd.tm - cur.tm;
          if (diff < window) begin
            idx = i;
            break;
          end
        end
        if (idx >= 0) begin
          cur = hits[sec][idx];
          if (cmd.tm < cur.tm) begin
            cur.pk = cmd.pk;
            cur.tr = cmd.tr;
          end
          num = 64'(cur.tm) * 64'(cur.en) + 64'(cmd.tm) * 64'(cmd.en);
          den = 64'(cur.en) + 64'(cmd.en);
          cur.tm = 24'(num / den);
          cur.en = (den > 64'(Max24)) ? Max24 : den[23:0];
          hits[sec][idx] = cur;
          push_status(dhma_pkg::StMerged, cur);
          merges++;
        end else if (fill[sec] < HitsPerSector) begin
          hits[sec][fill[sec]] = cmd;
          fill[sec]++;
          push_status(dhma_pkg::StCreated, cmd);
          creates++;
        end else begin
          push_status(dhma_pkg::StFull, zero);
          fulls++;
        end
      end else begin
        k = 0;
        for (int i = 0; i < fill[sec]; i++) begin
          cur = hits[sec][i];
          if (cur.en > threshold) begin
            r.kind = dhma_pkg::KindHit; r.status = dhma_pkg::StMerged;
            r.tm = cur.tm; r.en = cur.en;
            r.pk = cur.pk; r.tr = cur.tr; r.last = 1'b0;
            pending.push_back(r);
            k++;
          end
        end
        fill[sec] = 0;
        if (k == 0) begin
          r.kind = dhma_pkg::KindEmpty; r.status = dhma_pkg::StMerged;
          r.tm = '0; r.en = '0;
          r.pk = '0; r.tr = '0; r.last = 1'b1;
          pending.push_back(r);
          empties++;
        end else begin
          r = pending.pop_back();
          r.last = 1'b1;
          pending.push_back(r);
          readout_hits += k;
        end
      end
    endfunction

    function void check_result(hit_result_t got);
      hit_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d status %0d", got.kind, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      matched++;
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status); errors++;
      end
      if (got.tm !== want.tm) begin
        $error("out_time: expected %0d, got %0d", want.tm, got.tm); errors++;
      end
      if (got.en !== want.en) begin
        $error("out_energy: expected %0d, got %0d", want.en, got.en); errors++;
      end
      if (got.pk !== want.pk) begin
        $error("out_particle: expected %0d, got %0d", want.pk, got.pk); errors++;
      end
      if (got.tr !== want.tr) begin
        $error("out_track: expected %0d, got %0d", want.tr, got.tr); errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               opcode_i;
  logic [4:0]         sector_i;
  logic [23:0]        hit_time_i;
  logic [23:0]        deposit_i;
  logic [7:0]         particle_kind_i;
  logic signed [15:0] track_number_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [23:0]        cfg_data_i;
  logic               result_valid_o;
  logic [1:0]         result_kind_o;
  logic [1:0]         status_o;
  logic [23:0]        out_time_o;
  logic [23:0]        out_energy_o;
  logic [7:0]         out_particle_o;
  logic signed [15:0] out_track_o;
  logic               last_o;

  hit_ledger   ledger;
  int unsigned quiet_cycles;  // cycles with no transaction of any kind
  bit          no_gaps;       // set for the closing stretch of the run
  int unsigned sent;

  detector_hit_merge_accumulator #(
    .SECTORS(NumSectors),
    .HITS_PER_SECTOR(HitsPerSector)
  ) dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .sector_i, .hit_time_i, .deposit_i,
    .particle_kind_i, .track_number_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .result_valid_o, .result_kind_o, .status_o, .out_time_o,
    .out_energy_o, .out_particle_o, .out_track_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are strobed for one full cycle; sampling mid-cycle avoids any
  // race with the RTL's edge updates.
  always @(negedge clk_i) begin
    hit_result_t got;
    if (rst_ni && result_valid_o) begin
      got.kind = result_kind_o; got.status = status_o; got.tm = out_time_o;
      got.en = out_energy_o; got.pk = out_particle_o; got.tr = out_track_o;
      got.last = last_o;
      ledger.check_result(got);
      quiet_cycles = 0;
    end
  end

  // Watchdog: any stretch without a transaction this long means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: %0d results still outstanding", ledger.pending.size());
        $display("tb_detector_hit_merge_accumulator failed");
        $finish;
      end
    end
  end

  // Write one register; only called with the block idle.
  task automatic write_reg(logic idx, logic [23:0] val);
    @(posedge clk_i);
    start <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ledger.set_reg(idx, val);
    quiet_cycles = 0;
  endtask

  // Present one command and hold start until the block takes it. Start stays
  // high after acceptance so a back-to-back command needs no second assignment
  // in the same time step; a gap lowers it first.
  task automatic send_command(logic op, logic [4:0] sec, dhma_pkg::entry_t cmd);
    int unsigned gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    sector_i <= sec;
    hit_time_i <= cmd.tm;
    deposit_i <= cmd.en;
    particle_kind_i <= cmd.pk;
    track_number_i <= cmd.tr;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    ledger.note_command(op, sec, cmd);
    quiet_cycles = 0;
    sent++;
  endtask

  task automatic deposit(logic [4:0] sec, logic [23:0] t, logic [23:0] e,
                         logic [7:0] p, logic signed [15:0] tr);
    dhma_pkg::entry_t cmd;
    cmd.tm = t; cmd.en = e; cmd.pk = p; cmd.tr = tr;
    send_command(dhma_pkg::OpDeposit, sec, cmd);
  endtask

  task automatic readout(logic [4:0] sec);
    dhma_pkg::entry_t cmd;
    cmd.tm = 24'($urandom); cmd.en = 24'($urandom);
    cmd.pk = 8'($urandom); cmd.tr = 16'($urandom);
    send_command(dhma_pkg::OpReadout, sec, cmd);
  endtask

  // Drop start in the step that took the last command, wait for every
  // expected result, then let the block settle before a register write or
  // the end of the run.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random commands. Sectors mostly come from a small pool so lists grow long
  // and fill; times cluster so merges happen at any nonzero window setting.
  task automatic random_run(int unsigned count, int unsigned pool, int unsigned rd_pct);
    logic [4:0]  sec;
    logic [23:0] t;
    logic [23:0] e;
    for (int n = 0; n < count; n++) begin
      sec = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, pool - 1));
      if ($urandom_range(0, 99) < rd_pct) begin
        readout(sec);
      end else begin
        case ($urandom_range(0, 3))
          0: t = 24'($urandom);
          1: t = 24'($urandom_range(0, 60000));
          2: t = 24'($urandom_range(0, 3));
          default: t = Max24 - 24'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 9))
          0: e = '0;
          1: e = Max24 - 24'($urandom_range(0, 2));
          2: e = 24'($urandom);
          default: e = 24'($urandom_range(1, 40000));
        endcase
        deposit(sec, t, e, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    ledger = new();
    quiet_cycles = 0;
    no_gaps = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = dhma_pkg::OpDeposit;
    sector_i = '0;
    hit_time_i = '0;
    deposit_i = '0;
    particle_kind_i = '0;
    track_number_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = dhma_pkg::CfgWindow;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values.
    deposit(5'd0, 24'd100, 24'd0, 8'd7, 16'sd3);            // zero energy, ignored
    deposit(5'd31, 24'd0, Max24, 8'd0, -16'sd1);            // extreme fields, created
    deposit(5'd31, Max24, 24'd1, 8'hFF, 16'sd32767);        // far in time, created
    deposit(5'd31, 24'd5, Max24, 8'd9, 16'sd9);             // merge, energy saturates
    deposit(5'd30, 24'd100, 24'd20000, 8'd1, 16'sd10);
    deposit(5'd30, 24'd50, 24'd20000, 8'd2, 16'sd20);       // earlier hit takes over id
    deposit(5'd30, 24'd16075, 24'd30000, 8'd3, 16'sd30);    // exactly one window away
    deposit(5'd30, 24'd16074, 24'd1, 8'd4, 16'sd40);        // just inside the window
    readout(5'd31);                                         // low-energy hit dropped
    readout(5'd30);
    readout(5'd30);                                         // cleared, so empty
    readout(5'd5);                                          // never used, empty
    drain();

    // Window zero: nothing merges; two sectors fill past capacity.
    write_reg(dhma_pkg::CfgWindow, 24'd0);
    write_reg(dhma_pkg::CfgThreshold, 24'd0);
    random_run(100, 2, 2);
    drain();

    // Narrowest real window, threshold at its top: every readout is empty.
    write_reg(dhma_pkg::CfgWindow, 24'd1);
    write_reg(dhma_pkg::CfgThreshold, Max24);
    random_run(80, 4, 10);
    drain();

    // Widest window: nearly everything merges into the first hit.
    write_reg(dhma_pkg::CfgWindow, Max24);
    write_reg(dhma_pkg::CfgThreshold, 24'd0);
    random_run(80, 4, 8);
    drain();

    // Random settings; the final stretch runs without gaps.
    write_reg(dhma_pkg::CfgWindow, 24'($urandom_range(1, 40000)));
    write_reg(dhma_pkg::CfgThreshold, 24'($urandom_range(0, 30000)));
    random_run(80, 6, 8);
    no_gaps = 1'b1;
    random_run(60, 6, 8);
    readout(5'd0);
    drain();

    $display("commands sent %0d, results checked %0d", sent, ledger.matched);
    $display("merged %0d created %0d full %0d ignored %0d readout hits %0d empty %0d",
             ledger.merges, ledger.creates, ledger.fulls, ledger.ignores,
             ledger.readout_hits, ledger.empties);
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("tb_detector_hit_merge_accumulator passed");
    end else begin
      $display("tb_detector_hit_merge_accumulator failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/dhma_pkg.sv
src/dhma_ram.sv
src/dhma_div.sv
src/detector_hit_merge_accumulator.sv
tb/sv/tb_detector_hit_merge_accumulator.sv
